// ===== hw/rtl/bm3_pkg.sv =====
// Shared constants and types for the 3x3 binary morphology block.
package bm3_pkg;

   // Default sizing of the line stores and the row counters
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4095;

   // Register field widths and reset values
   localparam int IMG_W_BITS = 11;
   localparam int IMG_H_BITS = 12;
   localparam logic [IMG_W_BITS-1:0] RST_WIDTH  = IMG_W_BITS'(640);
   localparam logic [IMG_H_BITS-1:0] RST_HEIGHT = IMG_H_BITS'(480);

   // APB port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // One line-store word holds {upper, middle} for a column
   localparam int LINE_BITS = 2;

   // Result queue
   localparam int OQ_DEPTH = 3;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 2;

   // Item operation codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // 3x3 window, indexed [row][column], row 0 is the upper line
   typedef logic [2:0][2:0] bm3_win_type;

   // Per-result filter control: image edge masks and mode
   typedef struct packed {
      logic row_up_ok;
      logic row_down_ok;
      logic col_left_ok;
      logic col_right_ok;
      logic four_conn;
      logic erode;
   } bm3_ctrl_type;

   // One result item
   typedef struct packed {
      logic result_object;
      logic end_of_row;
      logic end_of_frame;
   } bm3_rsp_type;

endpackage

// ===== hw/rtl/bm3_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module bm3_ram #(
   parameter int WIDTH  = bm3_pkg::LINE_BITS,
   parameter int DEPTH  = bm3_pkg::DEF_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/bm3_filter.sv =====
// 3x3 dilation / erosion of one window with edge and 4-connected masking.
module bm3_filter (
   input  bm3_pkg::bm3_win_type  win,
   input  bm3_pkg::bm3_ctrl_type ctrl,
   output logic                  result
);
   import bm3_pkg::*;

   logic [2:0]  row_ok;
   logic [2:0]  col_ok;
   bm3_win_type mask;
   logic        any_obj;
   logic        all_obj;

   always_comb begin
      row_ok = {ctrl.row_down_ok, 1'b1, ctrl.row_up_ok};
      col_ok = {ctrl.col_right_ok, 1'b1, ctrl.col_left_ok};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            // corners drop out of the cross neighborhood
            mask[r][c] = row_ok[r] & col_ok[c] & (~ctrl.four_conn | (r == 1) | (c == 1));
         end
      end
      // outside pixels: background for dilation, object for erosion
      any_obj = |(win & mask);
      all_obj = &(win | ~mask);
      result  = ctrl.erode ? all_obj : any_obj;
   end

endmodule

// ===== hw/rtl/binary_morphology_3x3.sv =====
// Top level: streaming 3x3 binary dilation / erosion with APB register port.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  req     | req_valid/req_ready  | req_operation, req_pixel_object
//  rsp     | rsp_valid/rsp_ready  | rsp_result_object, rsp_end_of_row,
//          |                      | rsp_end_of_frame
//  csr     | psel/penable/pready  | pwrite, paddr, pwdata, prdata
//
// Throughput is one item per clock while req_ready is high. An accepted item
// reads the shared line store (one 2-bit RAM word per column: upper and middle
// line) on the accept edge; the next cycle shifts the window, filters it and
// writes the RAM back. A result passes from the stage register into the result
// queue and shows on rsp from there. Reset clears counters, window, registers
// and the result queue; the line store has no clearing pass, since unwritten
// entries only reach masked taps. A 3-deep result queue absorbs rsp stalls;
// req_ready drops only when the queue plus the item in flight would fill it.
module binary_morphology_3x3 #(
   parameter int MAX_WIDTH  = bm3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bm3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // pixel items in
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic                           req_pixel_object,
   // filtered pixels out
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_result_object,
   output logic                           rsp_end_of_row,
   output logic                           rsp_end_of_frame,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bm3_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bm3_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bm3_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bm3_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int IROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W = $clog2(MAX_HEIGHT);

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH    = 2'd0,
      REG_IMAGE_HEIGHT   = 2'd1,
      REG_ERODE_MODE     = 2'd2,
      REG_FOUR_CONNECTED = 2'd3
   } bm3_reg_type;

   // ---------------------------------------------------------------- registers
   logic [IMG_W_BITS-1:0] width_ff;
   logic [IMG_H_BITS-1:0] height_ff;
   logic                  erode_ff;
   logic                  four_ff;
   logic                  csr_wr;
   bm3_reg_type           reg_sel;

   assign csr_wr  = psel & penable & pwrite;
   assign reg_sel = bm3_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         erode_ff  <= 1'b0;
         four_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:    width_ff  <= pwdata[IMG_W_BITS-1:0];
            REG_IMAGE_HEIGHT:   height_ff <= pwdata[IMG_H_BITS-1:0];
            REG_ERODE_MODE:     erode_ff  <= pwdata[0];
            REG_FOUR_CONNECTED: four_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:    prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:   prdata = CSR_DATA_W'(height_ff);
         REG_ERODE_MODE:     prdata = CSR_DATA_W'(erode_ff);
         REG_FOUR_CONNECTED: prdata = CSR_DATA_W'(four_ff);
         default:            prdata = '0;
      endcase
   end

   // Effective frame size: zero acts as one, clamp width to the store size and height to MAX_HEIGHT
   logic [WID_W-1:0]  eff_w;
   logic [IROW_W-1:0] eff_h;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = IROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = IROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = IROW_W'(height_ff);
      end
   end

   // ------------------------------------------------ accept side / counters
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [IROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;

   logic acc, act, draining, pix, emit;
   logic in_col_last, out_eor, out_row_last, out_eof;
   bm3_ctrl_type ctrl;

   assign acc      = req_valid & req_ready;
   // in_row saturates at MAX_HEIGHT; every height compare stays exact
   assign draining = (in_row_ff >= eff_h);
   // an early drain tick is swallowed without touching state
   assign act      = acc & ((req_operation == OP_PIXEL) | draining);
   assign pix      = draining ? 1'b0 : req_pixel_object;

   assign in_col_last  = (({1'b0, in_col_ff} + 1'b1) >= eff_w);
   assign emit         = (in_row_ff >= IROW_W'(2))
                       | ((in_row_ff == IROW_W'(1)) & (in_col_ff != '0));
   assign out_eor      = (({1'b0, out_col_ff} + 1'b1) >= eff_w);
   assign out_row_last = (({1'b0, out_row_ff} + 1'b1) >= eff_h);
   assign out_eof      = out_eor & out_row_last;

   always_comb begin
      ctrl.row_up_ok    = (out_row_ff != '0);
      ctrl.row_down_ok  = ~out_row_last;
      ctrl.col_left_ok  = (out_col_ff != '0);
      ctrl.col_right_ok = ~out_eor;
      ctrl.four_conn    = four_ff;
      ctrl.erode        = erode_ff;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (act) begin
         if (in_col_last) begin
            in_col_in = '0;
            if (in_row_ff != IROW_W'(MAX_HEIGHT)) begin
               in_row_in = in_row_ff + 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (emit) begin
            if (out_eof) begin
               // frame done: next item starts a fresh frame
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_eor) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------------------------------------- stage register (in flight)
   logic                 s1_act_ff, s1_emit_ff;
   logic                 s1_pix_ff, s1_eor_ff, s1_eof_ff;
   logic [COL_W-1:0]     s1_addr_ff;
   bm3_ctrl_type         s1_ctrl_ff;
   logic                 s1_fwd_ff;
   logic [LINE_BITS-1:0] s1_fwd_data_ff;

   logic [LINE_BITS-1:0] ram_rdata, line, line_wdata;
   logic                 up_pix, mid_pix, fwd_in;

   // same column written back while being read: take the write data
   assign fwd_in = s1_act_ff & (s1_addr_ff == in_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff  <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else begin
         s1_act_ff  <= act;
         s1_emit_ff <= act & emit;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff      <= pix;
      s1_eor_ff      <= out_eor;
      s1_eof_ff      <= emit & out_eof;
      s1_addr_ff     <= in_col_ff;
      s1_ctrl_ff     <= ctrl;
      s1_fwd_ff      <= fwd_in;
      s1_fwd_data_ff <= line_wdata;
   end

   bm3_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (s1_act_ff),
      .waddr (s1_addr_ff),
      .wdata (line_wdata),
      .raddr (in_col_ff),
      .rdata (ram_rdata)
   );

   assign line       = s1_fwd_ff ? s1_fwd_data_ff : ram_rdata;
   assign up_pix     = line[1];
   assign mid_pix    = line[0];
   // middle line moves up, new pixel becomes the middle line
   assign line_wdata = {mid_pix, s1_pix_ff};

   // ------------------------------------------------------- window and filter
   bm3_win_type window_ff, window_in, win_shift;
   logic        filt_res;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_shift[r][0] = window_ff[r][1];
         win_shift[r][1] = window_ff[r][2];
      end
      win_shift[0][2] = up_pix;
      win_shift[1][2] = mid_pix;
      win_shift[2][2] = s1_pix_ff;

      if (!s1_act_ff) begin
         window_in = window_ff;
      end else if (s1_eof_ff) begin
         window_in = '0;
      end else begin
         window_in = win_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   bm3_filter u_filter (
      .win    (win_shift),
      .ctrl   (s1_ctrl_ff),
      .result (filt_res)
   );

   // ----------------------------------------------------------- result queue
   bm3_rsp_type         q_ff [OQ_DEPTH];
   bm3_rsp_type         q_head;
   logic [OQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OQ_CNT_W-1:0] q_cnt_ff;
   logic                push, pop;

   assign push = s1_emit_ff;
   assign pop  = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{result_object: filt_res,
                              end_of_row:    s1_eor_ff,
                              end_of_frame:  s1_eof_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            q_cnt_ff <= q_cnt_ff + 1'b1;
         end else if (pop && !push) begin
            q_cnt_ff <= q_cnt_ff - 1'b1;
         end
      end
   end

   assign q_head            = q_ff[rd_ptr_ff];
   assign rsp_valid         = (q_cnt_ff != '0);
   assign rsp_result_object = q_head.result_object;
   assign rsp_end_of_row    = q_head.end_of_row;
   assign rsp_end_of_frame  = q_head.end_of_frame;

   // room for the item in flight plus a new one
   assign req_ready = ((OQ_CNT_W + 1)'(q_cnt_ff) + (OQ_CNT_W + 1)'(s1_emit_ff))
                    < (OQ_CNT_W + 1)'(OQ_DEPTH);

`ifndef SYNTHESIS
   // queue never pushed while full without a pop
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (q_cnt_ff != OQ_CNT_W'(OQ_DEPTH)))
      else $error("result queue overflow");

   // the stage register only holds an item right after it was accepted
   a_stage_from_accept: assert property (@(posedge clock) disable iff (reset)
      s1_act_ff |-> $past(req_valid && req_ready))
      else $error("stage active without an accepted item");

   // end of frame returns all counters to the frame start
   a_eof_clears_counters: assert property (@(posedge clock) disable iff (reset)
      (act && emit && out_eof) |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("counters not cleared at end of frame");

   // an end of frame result also closes its row
   a_eof_is_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_end_of_row)
      else $error("end of frame without end of row");
`endif

endmodule
